FILE: rtl/dsfs_pkg.sv
// Shared types and constants of the dual station fill sequencer.
`default_nettype none

package dsfs_pkg;

  localparam int unsigned TICK_W = 9;
  localparam int unsigned STEP_W = 5;
  localparam int unsigned DRV_W  = 6;

  localparam logic [1:0] CFG_OPEN   = 2'd0;
  localparam logic [1:0] CFG_SETTLE = 2'd1;
  localparam logic [1:0] CFG_RESUME = 2'd2;

  localparam logic [STEP_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [STEP_W-1:0] ST_MANUAL   = 5'd1;
  localparam logic [STEP_W-1:0] ST_START    = 5'd2;
  localparam logic [STEP_W-1:0] ST_FILL     = 5'd3;
  localparam logic [STEP_W-1:0] ST_PRESENCE = 5'd4;
  localparam logic [STEP_W-1:0] ST_POSITION = 5'd5;
  localparam logic [STEP_W-1:0] ST_OPEN     = 5'd6;
  localparam logic [STEP_W-1:0] ST_SETTLE   = 5'd7;
  localparam logic [STEP_W-1:0] ST_WAITCUP  = 5'd8;
  localparam logic [STEP_W-1:0] ST_RESUME   = 5'd9;
  localparam int unsigned       HALT_BIT    = 4;

  localparam int unsigned D_FLAP = 0;
  localparam int unsigned D_SHL  = 1;
  localparam int unsigned D_SHR  = 2;
  localparam int unsigned D_CHG  = 3;
  localparam int unsigned D_CONV = 4;
  localparam int unsigned D_MAN  = 5;

  localparam logic [1:0] STATUS_RUN    = 2'd0;
  localparam logic [1:0] STATUS_HALT   = 2'd1;
  localparam logic [1:0] STATUS_MANUAL = 2'd2;
  localparam logic [1:0] STATUS_WAIT   = 2'd3;

  localparam logic [1:0] PROMPT_NONE  = 2'd0;
  localparam logic [1:0] PROMPT_LEFT  = 2'd1;
  localparam logic [1:0] PROMPT_RIGHT = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] open_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] resume_ticks;
  } cfg_t;

  typedef struct packed {
    logic weight_left_n;
    logic weight_right_n;
    logic shutter_left_n;
    logic shutter_right_n;
    logic presence_left_n;
    logic presence_right_n;
    logic position_left_n;
    logic position_right_n;
    logic auto_mode;
    logic start_button_n;
    logic stop_button_n;
  } sample_t;

  typedef struct packed {
    logic       flap_right;
    logic       shutter_left_on;
    logic       shutter_right_on;
    logic       change_piston_on;
    logic       conveyor_on;
    logic       manual_lamp;
    logic [1:0] status;
    logic [1:0] prompt;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/dsfs_if.sv
// Valid/ready channel interfaces for sensor samples and drive results.
`default_nettype none

interface dsfs_in_if;
  logic valid;
  logic ready;
  logic weight_left_n;
  logic weight_right_n;
  logic shutter_left_n;
  logic shutter_right_n;
  logic presence_left_n;
  logic presence_right_n;
  logic position_left_n;
  logic position_right_n;
  logic auto_mode;
  logic start_button_n;
  logic stop_button_n;

  modport source (
    output valid, weight_left_n, weight_right_n, shutter_left_n, shutter_right_n,
           presence_left_n, presence_right_n, position_left_n, position_right_n,
           auto_mode, start_button_n, stop_button_n,
    input  ready
  );
  modport sink (
    input  valid, weight_left_n, weight_right_n, shutter_left_n, shutter_right_n,
           presence_left_n, presence_right_n, position_left_n, position_right_n,
           auto_mode, start_button_n, stop_button_n,
    output ready
  );
endinterface

interface dsfs_out_if;
  logic       valid;
  logic       ready;
  logic       flap_right;
  logic       shutter_left_on;
  logic       shutter_right_on;
  logic       change_piston_on;
  logic       conveyor_on;
  logic       manual_lamp;
  logic [1:0] status;
  logic [1:0] prompt;

  modport source (
    output valid, flap_right, shutter_left_on, shutter_right_on, change_piston_on,
           conveyor_on, manual_lamp, status, prompt,
    input  ready
  );
  modport sink (
    input  valid, flap_right, shutter_left_on, shutter_right_on, change_piston_on,
           conveyor_on, manual_lamp, status, prompt,
    output ready
  );
endinterface

`default_nettype wire

FILE: rtl/dsfs_seq.sv
// Sequencer state and per-tick step logic of the fill machine.
`default_nettype none

module dsfs_seq
  import dsfs_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 9
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    adv_i,
  input  wire cfg_t    cfg_i,
  input  wire sample_t smp_i,
  output result_t      res_o
);

  localparam int unsigned CMP_W = ((COUNT_BITS > TICK_W) ? COUNT_BITS : TICK_W) + 1;

  logic [STEP_W-1:0]     step_q, step_d;
  logic                  side_q, side_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]            fresh_q, fresh_d;
  logic [1:0]            gone_q, gone_d;
  logic                  waited_q, waited_d;
  logic                  shown_q, shown_d;
  logic                  conv_was_q, conv_was_d;
  logic [DRV_W-1:0]      drive_q, drive_d;

  logic [1:0]            w, sh, pr, po;
  logic                  sd, ot;
  logic                  start_p, stop_p;
  logic                  conv_gate;
  logic                  gone_w, fresh_w;
  logic [TICK_W-1:0]     tick_sel;
  logic                  cnt_done;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [3:0]            base;
  logic [1:0]            status;
  logic [1:0]            prompt;

  assign w  = {smp_i.weight_right_n, smp_i.weight_left_n};
  assign sh = {smp_i.shutter_right_n, smp_i.shutter_left_n};
  assign pr = {smp_i.presence_right_n, smp_i.presence_left_n};
  assign po = {smp_i.position_right_n, smp_i.position_left_n};
  assign sd = side_q;
  assign ot = ~side_q;
  assign start_p = ~smp_i.start_button_n;
  assign stop_p  = ~smp_i.stop_button_n;
  assign base    = step_q[3:0];

  assign conv_gate = ~((sh[0] & sh[1]) | (~w[0] & ~w[1]));
  assign gone_w    = pr[ot];
  assign fresh_w   = fresh_q[ot] | (~pr[ot] & gone_q[ot]);

  always_comb begin
    case (step_q)
      ST_OPEN:   tick_sel = cfg_i.open_ticks;
      ST_SETTLE: tick_sel = cfg_i.settle_ticks;
      default:   tick_sel = cfg_i.resume_ticks;
    endcase
  end

  assign cnt_done = ((CMP_W'(cnt_q) + CMP_W'(1)) >= CMP_W'(tick_sel)) || (cnt_q == '1);
  assign cnt_next = cnt_done ? '0 : cnt_q + COUNT_BITS'(1);

  always_comb begin
    step_d     = step_q;
    side_d     = side_q;
    cnt_d      = cnt_q;
    fresh_d    = fresh_q;
    gone_d     = gone_q;
    waited_d   = waited_q;
    shown_d    = shown_q;
    conv_was_d = conv_was_q;
    drive_d    = drive_q;

    if (!smp_i.auto_mode) begin
      drive_d        = '0;
      drive_d[D_MAN] = 1'b1;
      fresh_d        = 2'b11;
      side_d         = 1'b0;
      cnt_d          = '0;
      waited_d       = 1'b0;
      shown_d        = 1'b0;
      conv_was_d     = 1'b0;
      step_d         = ST_MANUAL;
    end else if (step_q[HALT_BIT]) begin
      if (base < ST_START[3:0] || base > ST_RESUME[3:0]) begin
        step_d = ST_IDLE;
      end else if (start_p) begin
        if (conv_was_q) begin
          drive_d[D_CONV] = 1'b1;
          conv_was_d      = 1'b0;
        end
        step_d = {1'b0, base};
      end
    end else if (step_q == ST_MANUAL) begin
      drive_d = '0;
      step_d  = ST_IDLE;
    end else if (step_q >= ST_START && step_q <= ST_RESUME) begin
      unique case (step_q)
        ST_START: begin
          if (w[sd] && !sh[sd]) begin
            drive_d[D_FLAP] = sd;
            drive_d[D_CONV] = 1'b1;
            step_d          = ST_FILL;
          end else begin
            step_d = ST_PRESENCE;
          end
        end
        ST_FILL: begin
          if (w[sd]) begin
            drive_d[D_CONV] = conv_gate;
            gone_d[ot]      = gone_w;
            fresh_d[ot]     = fresh_w;
          end else begin
            step_d = ST_PRESENCE;
          end
        end
        ST_PRESENCE: begin
          if (pr[sd]) begin
            drive_d[D_CONV] = conv_gate;
            gone_d[ot]      = gone_w;
            fresh_d[ot]     = fresh_w;
          end else begin
            step_d = ST_POSITION;
          end
        end
        ST_POSITION: begin
          if (po[sd]) begin
            drive_d[D_CONV] = conv_gate;
            gone_d[ot]      = gone_w;
            fresh_d[ot]     = fresh_w;
          end else begin
            if (!sh[ot]) drive_d[D_FLAP] = ot;
            else drive_d[D_CONV] = 1'b0;
            if (!pr[sd]) begin
              if (sd) drive_d[D_SHR] = 1'b1;
              else drive_d[D_SHL] = 1'b1;
              cnt_d  = '0;
              step_d = ST_OPEN;
            end else begin
              side_d = ot;
              step_d = ST_START;
            end
          end
        end
        ST_OPEN: begin
          gone_d[ot]      = gone_w;
          fresh_d[ot]     = fresh_w;
          drive_d[D_CONV] = conv_gate;
          if (!shown_q && !fresh_w) shown_d = 1'b1;
          cnt_d = cnt_next;
          if (cnt_done) begin
            if (sd) drive_d[D_SHR] = 1'b0;
            else drive_d[D_SHL] = 1'b0;
            fresh_d[sd] = 1'b0;
            step_d      = ST_SETTLE;
          end
        end
        ST_SETTLE: begin
          gone_d[ot]      = gone_w;
          fresh_d[ot]     = fresh_w;
          drive_d[D_CONV] = conv_gate;
          if (!w[ot]) drive_d[D_FLAP] = sd;
          cnt_d = cnt_next;
          if (cnt_done) step_d = ST_WAITCUP;
        end
        ST_WAITCUP: begin
          if (!fresh_q[ot]) begin
            gone_d[ot]      = gone_w;
            fresh_d[ot]     = fresh_w;
            shown_d         = 1'b1;
            drive_d[D_CONV] = conv_gate;
            waited_d        = 1'b1;
          end else begin
            shown_d = 1'b0;
            cnt_d   = '0;
            if (waited_q) begin
              step_d = ST_RESUME;
            end else begin
              drive_d[D_CHG] = ~sd;
              side_d         = ot;
              step_d         = ST_START;
            end
          end
        end
        ST_RESUME: begin
          drive_d[D_CONV] = conv_gate;
          cnt_d           = cnt_next;
          if (cnt_done) begin
            waited_d       = 1'b0;
            drive_d[D_CHG] = ~sd;
            side_d         = ot;
            step_d         = ST_START;
          end
        end
        default: begin
        end
      endcase
      if (stop_p) begin
        if (drive_d[D_CONV]) begin
          drive_d[D_CONV] = 1'b0;
          conv_was_d      = 1'b1;
        end
        step_d[HALT_BIT] = 1'b1;
      end
    end else begin
      step_d = ST_IDLE;
      if (start_p) begin
        side_d   = 1'b0;
        cnt_d    = '0;
        fresh_d  = 2'b11;
        waited_d = 1'b0;
        step_d   = ST_START;
      end
    end
  end

  always_comb begin
    if (step_d == ST_MANUAL) status = STATUS_MANUAL;
    else if (step_d[HALT_BIT]) status = STATUS_HALT;
    else if (step_d >= ST_START && step_d <= ST_RESUME) status = STATUS_RUN;
    else status = STATUS_WAIT;
  end

  always_comb begin
    prompt = PROMPT_NONE;
    if (status == STATUS_RUN && shown_d && !fresh_d[~side_d]) begin
      prompt = side_d ? PROMPT_LEFT : PROMPT_RIGHT;
    end
  end

  assign res_o.flap_right       = drive_d[D_FLAP];
  assign res_o.shutter_left_on  = drive_d[D_SHL];
  assign res_o.shutter_right_on = drive_d[D_SHR];
  assign res_o.change_piston_on = drive_d[D_CHG];
  assign res_o.conveyor_on      = drive_d[D_CONV];
  assign res_o.manual_lamp      = drive_d[D_MAN];
  assign res_o.status           = status;
  assign res_o.prompt           = prompt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= ST_IDLE;
      side_q     <= 1'b0;
      cnt_q      <= '0;
      fresh_q    <= 2'b11;
      gone_q     <= 2'b00;
      waited_q   <= 1'b0;
      shown_q    <= 1'b0;
      conv_was_q <= 1'b0;
      drive_q    <= '0;
    end else if (adv_i) begin
      step_q     <= step_d;
      side_q     <= side_d;
      cnt_q      <= cnt_d;
      fresh_q    <= fresh_d;
      gone_q     <= gone_d;
      waited_q   <= waited_d;
      shown_q    <= shown_d;
      conv_was_q <= conv_was_d;
      drive_q    <= drive_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dual_station_fill_sequencer_top.sv
// Dual station fill sequencer: sample pipeline, tick registers and sequencer.
//
// Usage: present one sensor/button sample per 10 ms tick on in_i; each
// transfer on in_i yields exactly one result transfer on out_o carrying the
// piston, flap, conveyor and lamp drives plus status and prompt codes.
// The block is a two-register pipeline: a sample register and a result
// register with the sequencer logic between them. One sample per cycle is
// sustained while out_o accepts results, set by the single sequencer update
// per cycle.
// The tick registers (open, settle, resume) are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no sample
// is in flight, which the block does not enforce. Unknown indexes are ignored.
// Reset: both pipeline stages empty, sequencer awaiting start, all drives
// off, tick registers at 101, 301 and 201.
// A stalled out_o holds its result; an empty sample register still takes
// one more sample, after which in_i.ready drops until out_o moves again.
`default_nettype none

module dual_station_fill_sequencer_top
  import dsfs_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 9
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  dsfs_in_if.sink                in_i,
  dsfs_out_if.source             out_o,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [TICK_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  sample_t smp_q, smp_d;
  logic    smp_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    adv;

  assign adv      = smp_vld_q & (~res_vld_q | out_o.ready);
  assign in_i.ready = ~smp_vld_q | adv;

  assign smp_d.weight_left_n    = in_i.weight_left_n;
  assign smp_d.weight_right_n   = in_i.weight_right_n;
  assign smp_d.shutter_left_n   = in_i.shutter_left_n;
  assign smp_d.shutter_right_n  = in_i.shutter_right_n;
  assign smp_d.presence_left_n  = in_i.presence_left_n;
  assign smp_d.presence_right_n = in_i.presence_right_n;
  assign smp_d.position_left_n  = in_i.position_left_n;
  assign smp_d.position_right_n = in_i.position_right_n;
  assign smp_d.auto_mode        = in_i.auto_mode;
  assign smp_d.start_button_n   = in_i.start_button_n;
  assign smp_d.stop_button_n    = in_i.stop_button_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_ticks   <= TICK_W'(101);
      cfg_q.settle_ticks <= TICK_W'(301);
      cfg_q.resume_ticks <= TICK_W'(201);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_OPEN:   cfg_q.open_ticks   <= cfg_data_i;
        CFG_SETTLE: cfg_q.settle_ticks <= cfg_data_i;
        CFG_RESUME: cfg_q.resume_ticks <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_i.ready) smp_vld_q <= in_i.valid;
      if (adv) res_vld_q <= 1'b1;
      else if (out_o.ready) res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) smp_q <= smp_d;
    if (adv) res_q <= res_d;
  end

  dsfs_seq #(
    .COUNT_BITS(COUNT_BITS)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .adv_i (adv),
    .cfg_i (cfg_q),
    .smp_i (smp_q),
    .res_o (res_d)
  );

  assign out_o.valid            = res_vld_q;
  assign out_o.flap_right       = res_q.flap_right;
  assign out_o.shutter_left_on  = res_q.shutter_left_on;
  assign out_o.shutter_right_on = res_q.shutter_right_on;
  assign out_o.change_piston_on = res_q.change_piston_on;
  assign out_o.conveyor_on      = res_q.conveyor_on;
  assign out_o.manual_lamp      = res_q.manual_lamp;
  assign out_o.status           = res_q.status;
  assign out_o.prompt           = res_q.prompt;

endmodule

`default_nettype wire

FILE: rtl/dsfs_checker.sv
// Port-level checks of the fill sequencer and their binding to the top level.
`default_nettype none

module dsfs_checker
  import dsfs_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       flap_right_i,
  input wire logic       shutter_left_on_i,
  input wire logic       shutter_right_on_i,
  input wire logic       change_piston_on_i,
  input wire logic       conveyor_on_i,
  input wire logic       manual_lamp_i,
  input wire logic [1:0] status_i,
  input wire logic [1:0] prompt_i
);

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) && $stable(prompt_i))
    else $error("result changed while stalled");

  a_manual_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (manual_lamp_i == (status_i == STATUS_MANUAL)))
    else $error("manual lamp disagrees with status");

  a_manual_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_MANUAL |->
      !flap_right_i && !shutter_left_on_i && !shutter_right_on_i &&
      !change_piston_on_i && !conveyor_on_i)
    else $error("drive active in manual mode");

  a_prompt_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && prompt_i != PROMPT_NONE |->
      status_i == STATUS_RUN && (prompt_i == PROMPT_LEFT || prompt_i == PROMPT_RIGHT))
    else $error("prompt shown outside running");

  a_one_shutter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(shutter_left_on_i && shutter_right_on_i))
    else $error("both shutters open");

endmodule

bind dual_station_fill_sequencer_top dsfs_checker u_dsfs_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .flap_right_i      (out_o.flap_right),
  .shutter_left_on_i (out_o.shutter_left_on),
  .shutter_right_on_i(out_o.shutter_right_on),
  .change_piston_on_i(out_o.change_piston_on),
  .conveyor_on_i     (out_o.conveyor_on),
  .manual_lamp_i     (out_o.manual_lamp),
  .status_i          (out_o.status),
  .prompt_i          (out_o.prompt)
);

`default_nettype wire
